/* rtl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the light-driven blind controller: config
// register layout, lux converter constants, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

  // Lux result width and saturation value
  localparam int unsigned LUX_BITS  = 15;
  localparam logic [LUX_BITS-1:0] LUX_MAX = 15'h7FFF;
  // Quotient bits resolved by the divider, one per step
  localparam int unsigned QUOT_STEPS = LUX_BITS;
  // Scale factor in the lux formula
  localparam int unsigned LUX_SCALE = 10;

  // Travel clamp
  localparam logic [11:0] TRAVEL_MAX = 12'd2048;

  // APB register map: register index sits at paddr[4:2]
  localparam int unsigned ADDR_BITS = 5;
  localparam logic [2:0] REG_THR_HIGH = 3'd0;
  localparam logic [2:0] REG_THR_LOW  = 3'd1;
  localparam logic [2:0] REG_DARK     = 3'd2;
  localparam logic [2:0] REG_LIT      = 3'd3;
  localparam logic [2:0] REG_CAL      = 3'd4;
  localparam logic [2:0] REG_TRAVEL   = 3'd5;

  // Register reset values
  localparam logic [9:0]  THR_HIGH_RST = 10'd540;
  localparam logic [9:0]  THR_LOW_RST  = 10'd470;
  localparam logic [15:0] DARK_RST     = 16'd1000;
  localparam logic [7:0]  LIT_RST      = 8'd15;
  localparam logic [7:0]  CAL_RST      = 8'd10;
  localparam logic [11:0] TRAVEL_RST   = 12'd512;

  // Blind position codes
  localparam logic [1:0] BLIND_CLOSED = 2'd0;
  localparam logic [1:0] BLIND_HALF   = 2'd1;
  localparam logic [1:0] BLIND_OPEN   = 2'd2;

  // Light bands already acted on
  localparam logic [2:0] BAND_NONE  = 3'b000;
  localparam logic [2:0] BAND_DAY   = 3'b001;
  localparam logic [2:0] BAND_MID   = 3'b010;
  localparam logic [2:0] BAND_NIGHT = 3'b100;

  typedef struct packed {
    logic [9:0]  thr_high;
    logic [9:0]  thr_low;
    logic [15:0] dark;
    logic [7:0]  lit;
    logic [7:0]  cal;
    logic [11:0] travel;
  } cfg_t;

  // Which value goes through the lux converter; thresholds come first
  typedef enum logic [1:0] {
    SRC_HIGH,
    SRC_LOW,
    SRC_OUT,
    SRC_IN
  } lux_src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_CHECK,
    ST_DIV,
    ST_DECIDE
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    lux_src_t src;
    logic     mul1;
    logic     mul2;
    logic     check;
    logic     div_step;
    logic     div_last;
    logic     decide;
  } cmd_t;

  typedef struct packed {
    logic sat;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/lbc_if.sv */
// ----------------------------------------------------------------------------
// lbc_if
// Valid/ready channels of the blind controller: sample beats in, result
// beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbc_in_if #(
  parameter int READING_BITS = 10
);
  logic                    valid;
  logic                    ready;
  logic [READING_BITS-1:0] outside_reading;
  logic [READING_BITS-1:0] inside_reading;
  logic                    light_button;
  logic                    blind_button;
  logic                    auto_button;

  modport source (
    output valid, outside_reading, inside_reading,
           light_button, blind_button, auto_button,
    input  ready
  );
  modport sink (
    input  valid, outside_reading, inside_reading,
           light_button, blind_button, auto_button,
    output ready
  );
endinterface

interface lbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] motor_steps;
  logic               room_light_on;
  logic               auto_led_on;

  modport source (
    output valid, motor_steps, room_light_on, auto_led_on,
    input  ready
  );
  modport sink (
    input  valid, motor_steps, room_light_on, auto_led_on,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/light_driven_blind_controller_core.sv */
// ----------------------------------------------------------------------------
// light_driven_blind_controller_core
// Blind and room light controller driven by exterior and interior light
// samples, with an APB register file for thresholds and sensor constants.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------
//   in_ch   | in  | valid/ready        | two light readings, three buttons
//   out_ch  | out | valid/ready        | motor steps, room light, auto LED
//   apb     | in  | psel/penable/pready| six config registers at 4*i
//
// A sample is accepted, then goes through two lux conversions (two multiply
// stages, a saturation check, 15 divide steps on the one shared divider),
// then a decision step. A conversion that saturates ends at its check.
// After a config write the next sample also reconverts both thresholds.
// Reset is synchronous and leaves the block idle. A waiting result holds
// the block in its decision state, and no new sample is taken until the
// result beat is free.
// ----------------------------------------------------------------------------
`default_nettype none

module light_driven_blind_controller_core #(
  parameter int READING_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lbc_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  lbc_in_if.sink                             in_ch,
  lbc_out_if.source                          out_ch
);
  import lbc_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  stat_t      stat;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr_high <= THR_HIGH_RST;
      cfg.thr_low  <= THR_LOW_RST;
      cfg.dark     <= DARK_RST;
      cfg.lit      <= LIT_RST;
      cfg.cal      <= CAL_RST;
      cfg.travel   <= TRAVEL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THR_HIGH: cfg.thr_high <= pwdata[9:0];
        REG_THR_LOW:  cfg.thr_low  <= pwdata[9:0];
        REG_DARK:     cfg.dark     <= pwdata[15:0];
        REG_LIT:      cfg.lit      <= pwdata[7:0];
        REG_CAL:      cfg.cal      <= pwdata[7:0];
        REG_TRAVEL:   cfg.travel   <= pwdata[11:0];
        default:      cfg.travel   <= cfg.travel;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_THR_HIGH: prdata = 32'(cfg.thr_high);
      REG_THR_LOW:  prdata = 32'(cfg.thr_low);
      REG_DARK:     prdata = 32'(cfg.dark);
      REG_LIT:      prdata = 32'(cfg.lit);
      REG_CAL:      prdata = 32'(cfg.cal);
      REG_TRAVEL:   prdata = 32'(cfg.travel);
      default:      prdata = '0;
    endcase
  end

  lbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cfg_wr   (cfg_wr),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbc_datapath #(
    .READING_BITS (READING_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .outside_reading (in_ch.outside_reading),
    .inside_reading  (in_ch.inside_reading),
    .light_button    (in_ch.light_button),
    .blind_button    (in_ch.blind_button),
    .auto_button     (in_ch.auto_button),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .motor_steps     (out_ch.motor_steps),
    .room_light_on   (out_ch.room_light_on),
    .auto_led_on     (out_ch.auto_led_on)
  );

endmodule

`default_nettype wire

/* rtl/lbc_ctrl.sv */
// ----------------------------------------------------------------------------
// lbc_ctrl
// Sequencer: walks each lux conversion through multiply, saturation check
// and the bit-serial divide, then issues the mode decision.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          cfg_wr,
  input  wire lbc_pkg::stat_t stat,
  output lbc_pkg::cmd_t      cmd
);
  import lbc_pkg::*;

  localparam logic [3:0] CNT_LAST = 4'(QUOT_STEPS - 1);

  ctrl_state_t state, state_next;
  lux_src_t    src;
  logic [3:0]  cnt;
  logic        dirty;
  logic        lux_done;

  // One conversion finishes on a saturated check or the last divide step
  assign lux_done = ((state == ST_CHECK) && stat.sat) ||
                    ((state == ST_DIV) && (cnt == CNT_LAST));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_CHECK;
      ST_CHECK: begin
        if (stat.sat) state_next = (src == SRC_IN) ? ST_DECIDE : ST_MUL1;
        else          state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CNT_LAST) state_next = (src == SRC_IN) ? ST_DECIDE : ST_MUL1;
      end
      ST_DECIDE: if (stat.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd     = '0;
    cmd.src = src;
    case (state)
      ST_IDLE:   cmd.capture = in_valid;
      ST_MUL1:   cmd.mul1 = 1'b1;
      ST_MUL2:   cmd.mul2 = 1'b1;
      ST_CHECK:  cmd.check = 1'b1;
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (cnt == CNT_LAST);
      end
      ST_DECIDE: cmd.decide = stat.out_free;
      default:   cmd = '0;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  // Hold state, conversion index and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      src   <= SRC_HIGH;
      cnt   <= '0;
      dirty <= 1'b1;
    end else begin
      state <= state_next;
      // thresholds are reconverted only after reset or a config write
      if (cfg_wr)               dirty <= 1'b1;
      else if (cmd.capture)     dirty <= 1'b0;
      if (cmd.capture)          src <= dirty ? SRC_HIGH : SRC_OUT;
      else if (lux_done)        src <= lux_src_t'(src + 2'd1);
      if (state == ST_CHECK)    cnt <= '0;
      else if (state == ST_DIV) cnt <= cnt + 4'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/lbc_datapath.sv */
// ----------------------------------------------------------------------------
// lbc_datapath
// Sample capture, lux converter (two multiply stages and a restoring
// divider, one quotient bit per step), mode logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_datapath #(
  parameter int READING_BITS = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire lbc_pkg::cfg_t           cfg,
  input  wire lbc_pkg::cmd_t           cmd,
  output lbc_pkg::stat_t               stat,
  input  wire logic [READING_BITS-1:0] outside_reading,
  input  wire logic [READING_BITS-1:0] inside_reading,
  input  wire logic                    light_button,
  input  wire logic                    blind_button,
  input  wire logic                    auto_button,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [12:0]           motor_steps,
  output logic                         room_light_on,
  output logic                         auto_led_on
);
  import lbc_pkg::*;

  localparam int RB    = READING_BITS;
  localparam int VD_W  = RB + 16;
  localparam int NUM_W = RB + 20;
  localparam int DEN_W = RB + 17;
  localparam int CMP_W = DEN_W + LUX_BITS;
  localparam int TW    = (RB > 10) ? RB : 10;
  localparam logic [RB:0] FULL_SCALE = {1'b1, {RB{1'b0}}};

  // captured sample
  logic [RB-1:0] out_rd, in_rd;
  logic          btn_light, btn_blind, btn_auto;

  // converter pipeline
  logic [RB-1:0]         v;
  logic [TW-1:0]         thr_high_ext, thr_low_ext;
  logic [VD_W-1:0]       p_vd;
  logic [15:0]           p_lc;
  logic [RB:0]           p_comp;
  logic [NUM_W-1:0]      num, rem;
  logic [DEN_W-1:0]      den;
  logic [CMP_W-1:0]      dsh, diff;
  logic [LUX_BITS-2:0]   q;
  logic                  ge, sat;
  logic                  lux_we;
  logic [LUX_BITS-1:0]   lux_val;
  logic [LUX_BITS-1:0]   lux_high, lux_low, lux_out, lux_in;

  // behavior state
  logic [1:0] pos, pos_next;
  logic [2:0] band, band_next;
  logic       room, room_next;
  logic       mark, mark_next;
  logic       auto_run, auto_run_next;
  logic       manual_run, manual_run_next;
  logic       ind, ind_next;
  logic signed [12:0] steps_next;

  logic [11:0]        full;
  logic signed [12:0] s_full, s_half, s_rest;

  // Select the value to convert; thresholds are masked to the reading width
  assign thr_high_ext = TW'(cfg.thr_high);
  assign thr_low_ext  = TW'(cfg.thr_low);
  always_comb begin
    case (cmd.src)
      SRC_HIGH: v = thr_high_ext[RB-1:0];
      SRC_LOW:  v = thr_low_ext[RB-1:0];
      SRC_OUT:  v = out_rd;
      SRC_IN:   v = in_rd;
      default:  v = out_rd;
    endcase
  end

  // Saturation check and one divide step
  assign sat  = (den == '0) || (CMP_W'(num) >= (CMP_W'(den) << LUX_BITS));
  assign ge   = (CMP_W'(rem) >= dsh);
  assign diff = CMP_W'(rem) - dsh;

  assign lux_we  = (cmd.check && sat) || cmd.div_last;
  assign lux_val = cmd.check ? LUX_MAX : {q, ge};

  // Capture the sample
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_rd    <= outside_reading;
      in_rd     <= inside_reading;
      btn_light <= light_button;
      btn_blind <= blind_button;
      btn_auto  <= auto_button;
    end
  end

  // Multiply, check, divide, store lux
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p_vd   <= VD_W'(v) * VD_W'(cfg.dark);
      p_lc   <= 16'(cfg.lit) * 16'(cfg.cal);
      p_comp <= FULL_SCALE - {1'b0, v};
    end
    if (cmd.mul2) begin
      num <= NUM_W'(p_vd) * NUM_W'(LUX_SCALE);
      den <= DEN_W'(p_lc) * DEN_W'(p_comp);
    end
    if (cmd.check) begin
      rem <= num;
      dsh <= CMP_W'(den) << (LUX_BITS - 1);
      q   <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? diff[NUM_W-1:0] : rem;
      dsh <= dsh >> 1;
      q   <= {q[LUX_BITS-3:0], ge};
    end
    if (lux_we) begin
      case (cmd.src)
        SRC_HIGH: lux_high <= lux_val;
        SRC_LOW:  lux_low  <= lux_val;
        SRC_OUT:  lux_out  <= lux_val;
        SRC_IN:   lux_in   <= lux_val;
        default:  lux_out  <= lux_val;
      endcase
    end
  end

  // Travel amounts
  assign full   = (cfg.travel > TRAVEL_MAX) ? TRAVEL_MAX : cfg.travel;
  assign s_full = signed'({1'b0, full});
  assign s_half = signed'({2'b00, full[11:1]});
  assign s_rest = s_full - s_half;

  // Mode decision
  always_comb begin
    pos_next        = pos;
    band_next       = band;
    room_next       = room;
    mark_next       = mark;
    auto_run_next   = auto_run;
    manual_run_next = manual_run;
    ind_next        = ind;
    steps_next      = '0;
    if (btn_light || btn_blind || manual_run) begin
      // manual mode
      ind_next = 1'b0;
      if (btn_light) room_next = ~room;
      if (btn_blind) begin
        case (pos)
          BLIND_CLOSED: begin
            steps_next = s_full;
            pos_next   = BLIND_OPEN;
          end
          BLIND_HALF: begin
            steps_next = s_rest;
            pos_next   = BLIND_OPEN;
          end
          BLIND_OPEN: begin
            steps_next = -s_full;
            pos_next   = BLIND_CLOSED;
          end
          default: pos_next = pos;
        endcase
      end
      manual_run_next = 1'b1;
      if (btn_auto) begin
        auto_run_next   = 1'b0;
        manual_run_next = 1'b0;
      end
    end else if (btn_auto != auto_run) begin
      // automatic mode: blind from exterior band
      ind_next = 1'b1;
      if ((lux_out > lux_high) && !band[0]) begin
        if (pos == BLIND_CLOSED)    steps_next = s_full;
        else if (pos == BLIND_HALF) steps_next = s_rest;
        pos_next  = BLIND_OPEN;
        band_next = BAND_DAY;
      end else if ((lux_out < lux_high) && (lux_out > lux_low) && !band[1]) begin
        if (pos == BLIND_CLOSED)    steps_next = s_half;
        else if (pos != BLIND_HALF) steps_next = -s_rest;
        pos_next  = BLIND_HALF;
        band_next = BAND_MID;
      end else if (!band[2] && (lux_out < lux_low)) begin
        if (pos == BLIND_HALF)        steps_next = -s_half;
        else if (pos != BLIND_CLOSED) steps_next = -s_full;
        pos_next  = BLIND_CLOSED;
        band_next = BAND_NIGHT;
      end
      // room light from interior level
      if ((lux_in > lux_low) && mark && room) begin
        room_next = 1'b0;
        mark_next = 1'b0;
      end else if ((lux_in < lux_low) && !mark && !room) begin
        room_next = 1'b1;
        mark_next = 1'b1;
      end
      auto_run_next = 1'b1;
    end
  end

  assign stat.sat      = sat;
  assign stat.out_free = !out_valid || out_ready;

  // Commit the decision and load the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= BLIND_CLOSED;
      band       <= BAND_NONE;
      room       <= 1'b0;
      mark       <= 1'b0;
      auto_run   <= 1'b0;
      manual_run <= 1'b0;
      ind        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.decide) begin
        pos        <= pos_next;
        band       <= band_next;
        room       <= room_next;
        mark       <= mark_next;
        auto_run   <= auto_run_next;
        manual_run <= manual_run_next;
        ind        <= ind_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      motor_steps   <= steps_next;
      room_light_on <= room_next;
      auto_led_on   <= ind_next;
    end
  end

endmodule

`default_nettype wire

/* sim/tb_light_driven_blind_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_light_driven_blind_controller_core
// Self-checking bench for the light-driven blind controller. A short table
// of directed samples is followed by random phases, each run under its own
// register setting. The extreme settings come first: zero divisors, saturated
// thresholds and travel above the clamp. Every result beat is compared with a
// typed value or a behavioral predictor of the blind, light and mode logic.
// Both channels idle at random, and one long result stall backs up the block.
// ----------------------------------------------------------------------------
module tb_light_driven_blind_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lbc_pkg::*;

  localparam int READING_BITS    = 10;
  localparam int NUM_REGS        = 6;
  localparam int NUM_DIRECTED    = 18;
  localparam int NUM_FIXED       = 5;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int CHUNK_ITEMS     = 20;
  localparam int PRESSURE_PHASE  = 1;
  localparam int HOLD_CYCLES     = 300;
  localparam int TAIL_CYCLES     = 80;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [READING_BITS-1:0] outside;
    logic [READING_BITS-1:0] interior;
    logic                    light;
    logic                    blind;
    logic                    auto_press;
  } sample_t;

  typedef struct packed {
    logic signed [12:0] steps;
    logic               light_on;
    logic               led;
  } response_t;

  typedef struct packed {
    sample_t   stim;
    logic      typed;
    response_t resp;
  } directed_row_t;

  localparam response_t UNTYPED = '0;

  // Directed walk from reset: mode entry and exit, every band move, equal
  // thresholds, both manual actions together
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{10'd0,    10'd0,    1'b0, 1'b0, 1'b0}, 1'b1, '{13'sd0,   1'b0, 1'b0}},
    '{'{10'd1023, 10'd1023, 1'b0, 1'b0, 1'b1}, 1'b1, '{13'sd512, 1'b0, 1'b1}},
    '{'{10'd1023, 10'd1023, 1'b0, 1'b0, 1'b1}, 1'b1, '{13'sd0,   1'b0, 1'b1}},
    '{'{10'd540,  10'd470,  1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd470,  10'd1023, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd512,  10'd0,    1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd0,    10'd1023, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd1023, 10'd512,  1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd512,  10'd512,  1'b1, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd512,  10'd512,  1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd512,  10'd512,  1'b1, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd0,    10'd0,    1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd0,    10'd0,    1'b0, 1'b1, 1'b1}, 1'b0, UNTYPED},
    '{'{10'd512,  10'd0,    1'b0, 1'b0, 1'b1}, 1'b0, UNTYPED},
    '{'{10'd512,  10'd0,    1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd512,  10'd0,    1'b0, 1'b0, 1'b1}, 1'b0, UNTYPED},
    '{'{10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd0,    10'd1023, 1'b1, 1'b1, 1'b1}, 1'b0, UNTYPED}
  };

  // Register settings at the edges of their ranges
  localparam cfg_t FIXED_SETTINGS [NUM_FIXED] = '{
    '{10'd1023, 10'd0,    16'd65535, 8'd255, 8'd255, 12'd2048},
    '{10'd0,    10'd1023, 16'd1,     8'd1,   8'd1,   12'd4095},
    '{10'd540,  10'd470,  16'd1000,  8'd0,   8'd10,  12'd1},
    '{10'd700,  10'd300,  16'd0,     8'd20,  8'd30,  12'd0},
    '{10'd600,  10'd400,  16'd2000,  8'd20,  8'd0,   12'd1000}
  };

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_BITS-1:0]   paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  lbc_in_if #(.READING_BITS(READING_BITS)) sample_ch ();
  lbc_out_if                               result_ch ();

  light_driven_blind_controller_core #(
    .READING_BITS (READING_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (sample_ch.sink),
    .out_ch  (result_ch.source)
  );

  // Predictor copy of the register file and controller state
  cfg_t model_cfg = '{THR_HIGH_RST, THR_LOW_RST, DARK_RST, LIT_RST, CAL_RST, TRAVEL_RST};
  logic [1:0] blind_pos   = BLIND_CLOSED;
  logic [2:0] bands_seen  = BAND_NONE;
  logic       room_on     = 1'b0;
  logic       light_mark  = 1'b0;
  logic       auto_run    = 1'b0;
  logic       man_run     = 1'b0;
  logic       led_on      = 1'b0;

  response_t pending_responses [$];
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;
  bit        send_idle      = 1'b0;
  bit        recv_idle      = 1'b0;
  bit        hold_request   = 1'b0;

  // Free-running clock, 10 ns
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH @%0t: %s", $realtime, what);
    end
  endtask

  // Convert a raw converter reading to lux, saturating
  function automatic logic [LUX_BITS-1:0] lux_of(input logic [READING_BITS-1:0] raw);
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    den = longint'(model_cfg.lit) * model_cfg.cal * ((1 << READING_BITS) - raw);
    if (den == 0) begin
      return LUX_MAX;
    end
    num = longint'(raw) * model_cfg.dark * LUX_SCALE;
    quo = num / den;
    return (quo > LUX_MAX) ? LUX_MAX : quo[LUX_BITS-1:0];
  endfunction

  // Advance the controller state by one sample and return its result beat
  function automatic response_t predict_blind_response(input sample_t s);
    logic [LUX_BITS-1:0] out_lux;
    logic [LUX_BITS-1:0] in_lux;
    logic [LUX_BITS-1:0] lim_hi;
    logic [LUX_BITS-1:0] lim_lo;
    int                  full;
    int                  half;
    int                  steps;
    response_t           r;
    out_lux = lux_of(s.outside);
    in_lux  = lux_of(s.interior);
    lim_hi  = lux_of(model_cfg.thr_high);
    lim_lo  = lux_of(model_cfg.thr_low);
    full    = (model_cfg.travel > TRAVEL_MAX) ? int'(TRAVEL_MAX) : int'(model_cfg.travel);
    half    = full / 2;
    steps   = 0;

    if (s.light || s.blind || man_run) begin
      // Manual mode: toggle light, swing blind between closed and open
      led_on = 1'b0;
      if (s.light) begin
        room_on = ~room_on;
      end
      if (s.blind) begin
        case (blind_pos)
          BLIND_CLOSED: begin
            steps     = full;
            blind_pos = BLIND_OPEN;
          end
          BLIND_HALF: begin
            steps     = full - half;
            blind_pos = BLIND_OPEN;
          end
          BLIND_OPEN: begin
            steps     = -full;
            blind_pos = BLIND_CLOSED;
          end
          default: ;
        endcase
      end
      man_run = 1'b1;
      if (s.auto_press) begin
        auto_run = 1'b0;
        man_run  = 1'b0;
      end
    end else if (s.auto_press != auto_run) begin
      // Automatic mode: follow the exterior band once per band
      led_on = 1'b1;
      if (out_lux > lim_hi && (bands_seen & BAND_DAY) == BAND_NONE) begin
        if (blind_pos == BLIND_CLOSED) begin
          steps = full;
        end else if (blind_pos == BLIND_HALF) begin
          steps = full - half;
        end
        blind_pos  = BLIND_OPEN;
        bands_seen = BAND_DAY;
      end else if (out_lux < lim_hi && out_lux > lim_lo &&
                   (bands_seen & BAND_MID) == BAND_NONE) begin
        if (blind_pos == BLIND_CLOSED) begin
          steps = half;
        end else if (blind_pos != BLIND_HALF) begin
          steps = -(full - half);
        end
        blind_pos  = BLIND_HALF;
        bands_seen = BAND_MID;
      end else if ((bands_seen & BAND_NIGHT) == BAND_NONE && out_lux < lim_lo) begin
        if (blind_pos == BLIND_HALF) begin
          steps = -half;
        end else if (blind_pos != BLIND_CLOSED) begin
          steps = -full;
        end
        blind_pos  = BLIND_CLOSED;
        bands_seen = BAND_NIGHT;
      end
      // Interior light follows the lower threshold
      if (in_lux > lim_lo && light_mark && room_on) begin
        room_on    = 1'b0;
        light_mark = 1'b0;
      end else if (in_lux < lim_lo && !light_mark && !room_on) begin
        room_on    = 1'b1;
        light_mark = 1'b1;
      end
      auto_run = 1'b1;
    end

    r.steps    = 13'(steps);
    r.light_on = room_on;
    r.led      = led_on;
    return r;
  endfunction

  function automatic logic [31:0] stored_value(input logic [2:0] idx);
    case (idx)
      REG_THR_HIGH: return 32'(model_cfg.thr_high);
      REG_THR_LOW:  return 32'(model_cfg.thr_low);
      REG_DARK:     return 32'(model_cfg.dark);
      REG_LIT:      return 32'(model_cfg.lit);
      REG_CAL:      return 32'(model_cfg.cal);
      REG_TRAVEL:   return 32'(model_cfg.travel);
      default:      return 32'd0;
    endcase
  endfunction

  // One APB transfer: setup, then access until pready; starts and ends on a falling edge
  task automatic apb_transfer(input bit is_write, input logic [2:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write one register with junk above its field, then read it back
  task automatic write_register(input logic [2:0] idx, input logic [15:0] field);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wdata = $urandom();
    case (idx)
      REG_THR_HIGH: begin
        wdata[9:0]         = field[9:0];
        model_cfg.thr_high = field[9:0];
      end
      REG_THR_LOW: begin
        wdata[9:0]        = field[9:0];
        model_cfg.thr_low = field[9:0];
      end
      REG_DARK: begin
        wdata[15:0]    = field;
        model_cfg.dark = field;
      end
      REG_LIT: begin
        wdata[7:0]    = field[7:0];
        model_cfg.lit = field[7:0];
      end
      REG_CAL: begin
        wdata[7:0]    = field[7:0];
        model_cfg.cal = field[7:0];
      end
      REG_TRAVEL: begin
        wdata[11:0]      = field[11:0];
        model_cfg.travel = field[11:0];
      end
      default: ;
    endcase
    apb_transfer(1'b1, idx, wdata, rdata);
    apb_transfer(1'b0, idx, 32'd0, rdata);
    if (rdata !== stored_value(idx)) begin
      note_mismatch($sformatf("register %0d read back %0h, expected %0h",
                              idx, rdata, stored_value(idx)));
    end
  endtask

  task automatic load_settings(input cfg_t s);
    write_register(REG_THR_HIGH, 16'(s.thr_high));
    write_register(REG_THR_LOW,  16'(s.thr_low));
    write_register(REG_DARK,     s.dark);
    write_register(REG_LIT,      16'(s.lit));
    write_register(REG_CAL,      16'(s.cal));
    write_register(REG_TRAVEL,   16'(s.travel));
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.thr_high = 10'($urandom_range(0, 1023));
    s.thr_low  = 10'($urandom_range(0, 1023));
    s.dark     = 16'($urandom_range(1, 65535));
    s.lit      = 8'($urandom_range(1, 255));
    s.cal      = 8'($urandom_range(1, 255));
    s.travel   = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(2049, 4095))
                                             : 12'($urandom_range(0, 2048));
    return s;
  endfunction

  // Favor readings around the thresholds and at the ends of the scale
  function automatic logic [READING_BITS-1:0] pick_reading();
    int v;
    case ($urandom_range(0, 6))
      0:       v = int'(model_cfg.thr_high) + int'($urandom_range(0, 6)) - 3;
      1:       v = int'(model_cfg.thr_low) + int'($urandom_range(0, 6)) - 3;
      2:       v = ($urandom_range(0, 1) == 0) ? 0 : 1023;
      3:       v = int'($urandom_range(model_cfg.thr_low, model_cfg.thr_high));
      default: v = int'($urandom_range(0, 1023));
    endcase
    if (v < 0) begin
      v = 0;
    end else if (v > 1023) begin
      v = 1023;
    end
    return 10'(v);
  endfunction

  // Mostly samples that make automatic mode act, some manual presses, some noise
  function automatic sample_t random_sample();
    sample_t     s;
    int unsigned pick;
    s.outside    = pick_reading();
    s.interior   = pick_reading();
    s.light      = 1'b0;
    s.blind      = 1'b0;
    s.auto_press = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      if (man_run) begin
        s.auto_press = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        s.auto_press = auto_run;
      end else begin
        s.auto_press = ~auto_run;
      end
    end else if (pick < 85) begin
      s.light      = 1'($urandom_range(0, 1));
      s.blind      = ~s.light | 1'($urandom_range(0, 1));
      s.auto_press = ($urandom_range(0, 3) == 0);
    end else begin
      s.light      = 1'($urandom_range(0, 1));
      s.blind      = 1'($urandom_range(0, 1));
      s.auto_press = 1'($urandom_range(0, 1));
    end
    return s;
  endfunction

  // Offer one sample beat; valid stays high on return so back-to-back beats need no gap
  task automatic offer_sample(input sample_t s, input bit use_typed, input response_t typed_resp);
    int unsigned gap;
    response_t   predicted;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      sample_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.outside_reading = s.outside;
    sample_ch.inside_reading  = s.interior;
    sample_ch.light_button    = s.light;
    sample_ch.blind_button    = s.blind;
    sample_ch.auto_button     = s.auto_press;
    sample_ch.valid           = 1'b1;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    predicted = predict_blind_response(s);
    pending_responses.push_back(use_typed ? typed_resp : predicted);
    @(negedge clk);
  endtask

  task automatic drain_responses();
    while (pending_responses.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result sink: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    response_t   want;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_request) begin
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = recv_idle ? $urandom_range(0, 13) : 0;
      if (stall != 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      if (pending_responses.size() == 0) begin
        note_mismatch($sformatf("result beat with nothing pending: steps %0d light %0b led %0b",
                                result_ch.motor_steps, result_ch.room_light_on,
                                result_ch.auto_led_on));
      end else begin
        want = pending_responses.pop_front();
        if (result_ch.motor_steps !== want.steps || result_ch.room_light_on !== want.light_on ||
            result_ch.auto_led_on !== want.led) begin
          note_mismatch($sformatf(
            "expected steps %0d light %0b led %0b, got steps %0d light %0b led %0b",
            $signed(want.steps), want.light_on, want.led, result_ch.motor_steps,
            result_ch.room_light_on, result_ch.auto_led_on));
        end
      end
      @(negedge clk);
    end
  end

  // Abort when no beat or register access moves for too long
  always @(posedge clk) begin
    if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Main sequence: reset, register defaults, directed table, random phases
  initial begin : stimulus
    logic [31:0] rdata;
    cfg_t        settings;
    rst                       = 1'b1;
    psel                      = 1'b0;
    penable                   = 1'b0;
    pwrite                    = 1'b0;
    paddr                     = '0;
    pwdata                    = '0;
    sample_ch.valid           = 1'b0;
    sample_ch.outside_reading = '0;
    sample_ch.inside_reading  = '0;
    sample_ch.light_button    = 1'b0;
    sample_ch.blind_button    = 1'b0;
    sample_ch.auto_button     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Check register defaults
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_transfer(1'b0, 3'(i), 32'd0, rdata);
      if (rdata !== stored_value(3'(i))) begin
        note_mismatch($sformatf("register %0d after reset reads %0h, expected %0h",
                                i, rdata, stored_value(3'(i))));
      end
    end

    // Walk the directed table under default settings
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      offer_sample(DIRECTED_ROWS[r].stim, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].resp);
    end
    sample_ch.valid = 1'b0;
    drain_responses();

    // Random phases, each under a fresh setting loaded while idle
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_FIXED) begin
        settings = FIXED_SETTINGS[p];
      end else begin
        settings = random_settings();
      end
      load_settings(settings);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % CHUNK_ITEMS == 0) begin
          send_idle = ($urandom_range(0, 3) != 0);
          recv_idle = ($urandom_range(0, 3) != 0);
        end
        // Hold the result side while samples keep coming
        if (p == PRESSURE_PHASE && n == 0) begin
          hold_request = 1'b1;
          send_idle    = 1'b0;
        end
        offer_sample(random_sample(), 1'b0, UNTYPED);
      end
      sample_ch.valid = 1'b0;
      drain_responses();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
